// File: rtl/core/hcd_pkg.sv
// shared types, codes and helpers for the chunked body decoder
// no dependencies; imported by every module of the block
`default_nettype none

package hcd_pkg;

   // input operation codes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_START = 1'b1;

   // configuration register indexes
   localparam int  CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_CHUNK = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_BODY  = 1'd1;

   localparam logic [31:0] MAX_CHUNK_RESET = 32'd1048576;
   localparam logic [31:0] MAX_BODY_RESET  = 32'd1048576;

   // result status codes
   localparam logic [2:0] ST_BUSY      = 3'd0;
   localparam logic [2:0] ST_DONE      = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [2:0] ST_CHUNK_BIG = 3'd3;
   localparam logic [2:0] ST_BODY_BIG  = 3'd4;

   // line end characters
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // number of bytes skipped after each chunk payload
   localparam logic [1:0] SKIP_BYTES = 2'd2;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_DATA,
      PH_SKIP,
      PH_FINAL,
      PH_DONE,
      PH_ERR_SIZE,
      PH_ERR_CHUNK,
      PH_ERR_BODY
   } phase_type;

   // decoder state apart from the size accumulator
   typedef struct packed {
      phase_type   phase;
      logic [31:0] chunk_left;
      logic [31:0] body_count;
      logic        digits_done;
      logic        saw_cr;
      logic [1:0]  skip_left;
   } state_type;

   typedef struct packed {
      logic [31:0] max_chunk;
      logic [31:0] max_body;
   } limits_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic [2:0] status;
   } result_type;

   // bit 4 flags a hex digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [2:0] phase_status(input phase_type ph);
      logic [2:0] s;
      case (ph)
         PH_DONE:      s = ST_DONE;
         PH_ERR_SIZE:  s = ST_BAD_SIZE;
         PH_ERR_CHUNK: s = ST_CHUNK_BIG;
         PH_ERR_BODY:  s = ST_BODY_BIG;
         default:      s = ST_BUSY;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/hcd_csr.sv
// limit registers of the chunked body decoder
// depends on hcd_pkg for register indexes and reset values
`default_nettype none

module hcd_csr
   import hcd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]               csr_data,
   output limits_type                     limits
);

   limits_type limits_ff;
   limits_type limits_in;

   // register write decode
   always_comb begin
      limits_in = limits_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_CHUNK: limits_in.max_chunk = csr_data;
            CSR_MAX_BODY:  limits_in.max_body  = csr_data;
            default:       limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_chunk <= MAX_CHUNK_RESET;
         limits_ff.max_body  <= MAX_BODY_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

`default_nettype wire

// File: rtl/core/hcd_step.sv
// next-state and result logic for one received byte
// depends on hcd_pkg for state, limit and result types
`default_nettype none

module hcd_step
   import hcd_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  wire logic                  op,
   input  wire logic [7:0]            in_byte,
   input  wire state_type             state,
   input  wire logic [COUNT_BITS-1:0] accum,
   input  wire limits_type            limits,
   output state_type                  state_in,
   output logic [COUNT_BITS-1:0]      accum_in,
   output result_type                 result
);

   localparam int CmpBits = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   logic [4:0]         hex;
   logic               crlf_seen;
   logic [CmpBits-1:0] size_wide;
   logic [CmpBits-1:0] chunk_wide;
   logic [31:0]        size32;
   logic [32:0]        body_sum;
   logic               chunk_over;
   logic               body_over;
   logic               accum_full;

   // size line decode and limit checks
   assign hex        = hex_digit(in_byte);
   assign crlf_seen  = state.saw_cr && (in_byte == CH_LF);
   assign size_wide  = CmpBits'(accum);
   assign chunk_wide = CmpBits'(limits.max_chunk);
   assign size32     = size_wide[31:0];
   assign body_sum   = {1'b0, state.body_count} + {1'b0, size32};
   assign chunk_over = size_wide > chunk_wide;
   assign body_over  = body_sum > {1'b0, limits.max_body};
   assign accum_full = accum[COUNT_BITS-1 -: 4] != 4'd0;

   always_comb begin
      state_in = state;
      accum_in = accum;
      result.data_valid = 1'b0;
      result.data_byte  = 8'd0;
      if (op == OP_START) begin
         state_in.phase       = PH_SIZE;
         state_in.chunk_left  = 32'd0;
         state_in.body_count  = 32'd0;
         state_in.digits_done = 1'b0;
         state_in.saw_cr      = 1'b0;
         state_in.skip_left   = 2'd0;
         accum_in             = '0;
      end else begin
         case (state.phase)
            // hex digits, ignored text, then cr lf
            PH_SIZE: begin
               state_in.saw_cr = (in_byte == CH_CR);
               if (crlf_seen) begin
                  accum_in             = '0;
                  state_in.digits_done = 1'b0;
                  state_in.saw_cr      = 1'b0;
                  if (chunk_over) begin
                     state_in.phase = PH_ERR_CHUNK;
                  end else if (body_over) begin
                     state_in.phase = PH_ERR_BODY;
                  end else if (size32 == 32'd0) begin
                     state_in.phase = PH_FINAL;
                  end else begin
                     state_in.body_count = body_sum[31:0];
                     state_in.chunk_left = size32;
                     state_in.phase      = PH_DATA;
                  end
               end else if (!state.digits_done) begin
                  if (!hex[4]) begin
                     state_in.digits_done = 1'b1;
                  end else if (accum_full) begin
                     state_in.phase = PH_ERR_SIZE;
                  end else begin
                     accum_in = {accum[COUNT_BITS-5:0], hex[3:0]};
                  end
               end
            end
            // chunk payload passes out
            PH_DATA: begin
               result.data_valid = 1'b1;
               result.data_byte  = in_byte;
               if (state.chunk_left != 32'd0) begin
                  state_in.chunk_left = state.chunk_left - 32'd1;
               end
               if (state_in.chunk_left == 32'd0) begin
                  state_in.skip_left = SKIP_BYTES;
                  state_in.phase     = PH_SKIP;
               end
            end
            // trailing bytes dropped unchecked
            PH_SKIP: begin
               if (state.skip_left != 2'd0) begin
                  state_in.skip_left = state.skip_left - 2'd1;
               end
               if (state_in.skip_left == 2'd0) begin
                  state_in.phase       = PH_SIZE;
                  state_in.digits_done = 1'b0;
                  state_in.saw_cr      = 1'b0;
                  accum_in             = '0;
               end
            end
            // last line discarded through cr lf
            PH_FINAL: begin
               if (crlf_seen) begin
                  state_in.saw_cr = 1'b0;
                  state_in.phase  = PH_DONE;
               end else begin
                  state_in.saw_cr = (in_byte == CH_CR);
               end
            end
            default: begin
               state_in = state;
            end
         endcase
      end
      result.status = phase_status(state_in.phase);
   end

endmodule

`default_nettype wire

// File: rtl/core/http_chunked_body_decoder.sv
// chunked transfer body decoder: one byte in, one result out per transaction
// requests pass the input register, then the result register; one byte per cycle
// sustained while rsp_stall is low, set by the single-pass byte logic between
// input and result registers; synchronous active-high reset clears decoder state
// and the valid flags of both pipeline stages, and loads both limit registers
// with 1048576; depends on hcd_pkg, hcd_csr and hcd_step
`default_nettype none

module http_chunked_body_decoder
   import hcd_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_op,
   input  wire logic [7:0]                req_in_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_data_valid,
   output logic [7:0]                     rsp_data_byte,
   output logic [2:0]                     rsp_status,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]               csr_data
);

   limits_type             limits;
   logic                   in_valid_ff, in_valid_in;
   logic                   in_op_ff, in_op_in;
   logic [7:0]             in_byte_ff, in_byte_in;
   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  accum_ff, accum_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             result_ff, result_in, step_result;
   state_type              step_state;
   logic [COUNT_BITS-1:0]  step_accum;
   logic                   out_ready;
   logic                   in_ready;
   logic                   fire;

   hcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .limits    (limits)
   );

   hcd_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .op       (in_op_ff),
      .in_byte  (in_byte_ff),
      .state    (state_ff),
      .accum    (accum_ff),
      .limits   (limits),
      .state_in (step_state),
      .accum_in (step_accum),
      .result   (step_result)
   );

   // pipeline flow control
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign in_ready  = !in_valid_ff || out_ready;
   assign fire      = in_valid_ff && out_ready;
   assign req_stall = !in_ready;

   // next values of input stage, decoder state and result stage
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      accum_in     = accum_ff;
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (in_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_op_in   = req_op;
            in_byte_in = req_in_byte;
         end
      end
      if (out_ready) begin
         out_valid_in = in_valid_ff;
      end
      if (fire) begin
         state_in  = step_state;
         accum_in  = step_accum;
         result_in = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         state_ff.phase       <= PH_SIZE;
         state_ff.chunk_left  <= 32'd0;
         state_ff.body_count  <= 32'd0;
         state_ff.digits_done <= 1'b0;
         state_ff.saw_cr      <= 1'b0;
         state_ff.skip_left   <= 2'd0;
         accum_ff             <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         accum_ff     <= accum_in;
      end
      in_op_ff   <= in_op_in;
      in_byte_ff <= in_byte_in;
      result_ff  <= result_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_valid = result_ff.data_valid;
   assign rsp_data_byte  = result_ff.data_byte;
   assign rsp_status     = result_ff.status;

   // a payload phase always has bytes left to pass
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_DATA |-> state_ff.chunk_left != 32'd0)
      else $error("data phase with no payload bytes left");

   // a skip phase always has bytes left to drop
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_SKIP |-> state_ff.skip_left != 2'd0)
      else $error("skip phase with no bytes left");

   // decoded data only while the body is still in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_status == ST_BUSY)
      else $error("data byte reported with a final status");

   // decoder state only moves when a transaction passes to the result stage
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff) && $stable(accum_ff))
      else $error("decoder state changed without a transaction");

endmodule

`default_nettype wire
